@@ src/spq_pkg.sv @@
// shared types and constants for the sorted priority queue
// depends on nothing; every other file takes its names by scope
`default_nettype none

package spq_pkg;

	localparam int unsigned CAPACITY_DEF    = 16;
	localparam int unsigned VALUE_WIDTH_DEF = 32;

	localparam int unsigned CMD_W    = 2;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned POS_W    = 4;
	localparam int unsigned LEN_W    = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_FIND   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2,
		ST_SPARE    = 2'd3
	} status_t;

	// per-cycle control broadcast along the chain
	typedef struct packed {
		logic cmp;
		logic ins;
		logic rem;
	} cell_ctrl_t;

	// flags a cell reports to its neighbour and to the top level
	typedef struct packed {
		logic gt;
		logic eq;
		logic at;
	} cell_flags_t;

endpackage

`default_nettype wire

@@ src/spq_if.sv @@
// valid/ready channel interfaces for request and response beats
// depends on spq_pkg for field widths
`default_nettype none

interface spq_req_if;
	logic                                valid;
	logic                                ready;
	logic        [spq_pkg::CMD_W-1:0]    cmd;
	logic signed [spq_pkg::DATA_W-1:0]   value;

	modport source (output valid, cmd, value, input ready);
	modport sink   (input valid, cmd, value, output ready);
endinterface

interface spq_rsp_if;
	logic                                valid;
	logic                                ready;
	logic        [spq_pkg::STATUS_W-1:0] status;
	logic        [spq_pkg::POS_W-1:0]    position;
	logic signed [spq_pkg::DATA_W-1:0]   head_value;
	logic                                head_valid;
	logic        [spq_pkg::LEN_W-1:0]    length;

	modport source (output valid, status, position, head_value, head_valid, length,
		input ready);
	modport sink   (input valid, status, position, head_value, head_valid, length,
		output ready);
endinterface

`default_nettype wire

@@ src/sorted_priority_queue_core.sv @@
// top level of the sorted priority queue: cell chain, control sequencer, result register
// depends on spq_pkg, spq_if and spq_cell
`default_nettype none

// Keeps up to CAPACITY signed values in descending order in a chain of cells,
// largest at cell 0. A request has a compare step and a shift step: in the
// accept cycle every cell compares its entry with the operand and keeps the
// flags; once no earlier response waits or it is taken, the chain shifts by
// one place (insert or remove) and the result is loaded into the output
// register. No new request is taken before that, but one may be taken while
// the last response still waits. Inserted values go ahead of equal entries;
// remove and find act on the first equal entry from the head.
module sorted_priority_queue_core #(
	parameter int unsigned CAPACITY    = spq_pkg::CAPACITY_DEF,
	parameter int unsigned VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	spq_req_if.sink    req,
	spq_rsp_if.source  rsp
);

	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned DW    = spq_pkg::DATA_W;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0]             count_q;
	spq_pkg::cmd_t                cmd_s1;
	logic signed [VALUE_WIDTH-1:0] operand_s1;

	logic signed [VALUE_WIDTH+DW-1:0] wide_in;
	logic signed [VALUE_WIDTH-1:0]    in_value;

	spq_pkg::cell_ctrl_t          ctrl;
	spq_pkg::cell_flags_t         flags [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] cell_q [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] cell_d [CAPACITY];

	logic             accept;
	logic             finish;
	logic             full;
	logic             match;
	logic             do_ins;
	logic             do_rem;
	logic [IDX_W-1:0] enc;
	logic [CNT_W-1:0] count_d;

	spq_pkg::status_t               status_d;
	logic [IDX_W+spq_pkg::POS_W-1:0] pos_wide;
	logic [CNT_W+spq_pkg::LEN_W-1:0] len_wide;
	logic [VALUE_WIDTH+DW-1:0]       head_wide;

	assign wide_in  = {{VALUE_WIDTH{req.value[DW-1]}}, req.value};
	assign in_value = wide_in[VALUE_WIDTH-1:0];

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign finish    = (state_q == S_EXEC) && (!rsp.valid || rsp.ready);

	assign full = (count_q == CNT_W'(CAPACITY));

	always_comb begin
		match = 1'b0;
		enc   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match = match | (flags[i].at & flags[i].eq);
			if (flags[i].at) begin
				enc = enc | IDX_W'(i);
			end
		end
	end

	assign do_ins = finish && (cmd_s1 == spq_pkg::CMD_INSERT) && !full;
	assign do_rem = finish && (cmd_s1 == spq_pkg::CMD_REMOVE) && match;

	assign ctrl.cmp = accept;
	assign ctrl.ins = do_ins;
	assign ctrl.rem = do_rem;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			spq_cell #(
				.VALUE_WIDTH(VALUE_WIDTH)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.occupied   (CNT_W'(g) < count_q),
				.cmp_value  (in_value),
				.operand    (operand_s1),
				.left_gt    ((g == 0) ? 1'b1 : flags[(g == 0) ? 0 : g - 1].gt),
				.left_value (cell_q[(g == 0) ? 0 : g - 1]),
				.right_value(cell_q[(g == CAPACITY - 1) ? g : g + 1]),
				.flags      (flags[g]),
				.value_q    (cell_q[g]),
				.value_d    (cell_d[g])
			);
		end
	endgenerate

	always_comb begin
		status_d = spq_pkg::ST_NOTFOUND;
		count_d  = count_q;
		pos_wide = '0;
		unique case (cmd_s1)
			spq_pkg::CMD_INSERT: begin
				if (full) begin
					status_d = spq_pkg::ST_FULL;
				end else begin
					status_d = spq_pkg::ST_OK;
					count_d  = count_q + CNT_W'(1);
					pos_wide = {{spq_pkg::POS_W{1'b0}}, enc};
				end
			end
			spq_pkg::CMD_REMOVE: begin
				if (match) begin
					status_d = spq_pkg::ST_OK;
					count_d  = count_q - CNT_W'(1);
					pos_wide = {{spq_pkg::POS_W{1'b0}}, enc};
				end
			end
			spq_pkg::CMD_FIND: begin
				if (match) begin
					status_d = spq_pkg::ST_OK;
					pos_wide = {{spq_pkg::POS_W{1'b0}}, enc};
				end
			end
			default: begin
				status_d = spq_pkg::ST_NOTFOUND;
			end
		endcase
	end

	assign len_wide  = {{spq_pkg::LEN_W{1'b0}}, count_d};
	assign head_wide = {{DW{cell_d[0][VALUE_WIDTH-1]}}, cell_d[0]};

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= spq_pkg::cmd_t'(req.cmd);
			operand_s1 <= in_value;
		end
		if (finish) begin
			rsp.status     <= status_d;
			rsp.position   <= pos_wide[spq_pkg::POS_W-1:0];
			rsp.length     <= len_wide[spq_pkg::LEN_W-1:0];
			rsp.head_valid <= (count_d != '0);
			rsp.head_value <= (count_d != '0) ? head_wide[DW-1:0] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rsp.valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (rsp.ready) begin
						rsp.valid <= 1'b0;
					end
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (finish) begin
						state_q   <= S_IDLE;
						count_q   <= count_d;
						rsp.valid <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ src/spq_cell.sv @@
// one storage cell of the sorted chain: compares, then shifts left, right or loads
// depends on spq_pkg for control and flag structs
`default_nettype none

module spq_cell #(
	parameter int unsigned VALUE_WIDTH = spq_pkg::VALUE_WIDTH_DEF
) (
	input  wire                           clk,
	input  wire spq_pkg::cell_ctrl_t      ctrl,
	input  wire                           occupied,
	input  wire logic signed [VALUE_WIDTH-1:0] cmp_value,
	input  wire logic signed [VALUE_WIDTH-1:0] operand,
	input  wire                           left_gt,
	input  wire logic signed [VALUE_WIDTH-1:0] left_value,
	input  wire logic signed [VALUE_WIDTH-1:0] right_value,
	output spq_pkg::cell_flags_t          flags,
	output logic signed [VALUE_WIDTH-1:0] value_q,
	output logic signed [VALUE_WIDTH-1:0] value_d
);

	logic gt_q;
	logic eq_q;

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			gt_q <= occupied && (value_q > cmp_value);
			eq_q <= occupied && (value_q == cmp_value);
		end
		value_q <= value_d;
	end

	always_comb begin
		flags.gt = gt_q;
		flags.eq = eq_q;
		flags.at = !gt_q && left_gt;
	end

	always_comb begin
		value_d = value_q;
		priority if (ctrl.ins && !gt_q) begin
			value_d = flags.at ? operand : left_value;
		end else if (ctrl.rem && !gt_q) begin
			value_d = right_value;
		end else begin
			value_d = value_q;
		end
	end

endmodule

`default_nettype wire
